FILE: src/bsc_pkg.sv
// shared types, constants and checksum helpers for the bech32 string codec
`timescale 1ns / 1ps

package bsc_pkg;

    // default longest human-readable part
    localparam int HRP_MAX_DEF = 32;

    // depth of the queue between front and back
    localparam int QDEPTH = 2;

    // command codes on the input tuser
    localparam logic [1:0] CMD_HRP  = 2'd0;
    localparam logic [1:0] CMD_DATA = 2'd1;
    localparam logic [1:0] CMD_END  = 2'd2;

    // status codes on the final word
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_SHORT   = 3'd1;
    localparam logic [2:0] ST_BADCHAR = 3'd2;
    localparam logic [2:0] ST_MIXED   = 3'd3;
    localparam logic [2:0] ST_BADSYM  = 3'd4;
    localparam logic [2:0] ST_CHKSUM  = 3'd5;
    localparam logic [2:0] ST_HRPLONG = 3'd6;

    // separator character
    localparam logic [7:0] SEP_CHAR = 8'h31;

    // bch generator terms
    localparam logic [29:0] GEN [5] = '{
        30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
    };

    // symbol to character table
    localparam logic [7:0] CHARSET [32] = '{
        "q", "p", "z", "r", "y", "9", "x", "8",
        "g", "f", "2", "t", "v", "d", "w", "0",
        "s", "3", "j", "n", "5", "4", "k", "h",
        "c", "e", "6", "m", "u", "a", "7", "l"
    };

    // classified input word passed from front to back
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] lc;
        logic       range_bad;
        logic       is_upper;
        logic       is_lower;
        logic       enc_bad;
        logic [4:0] enc_sym;
        logic [7:0] enc_char;
        logic       dec_bad;
        logic [4:0] dec_sym;
    } op_t;

    // one polymod step
    function automatic logic [29:0] pm_step(input logic [29:0] c, input logic [4:0] v);
        logic [4:0]  top;
        logic [29:0] r;
        top = c[29:25];
        r   = {c[24:0], v};
        for (int j = 0; j < 5; j++)
        begin
            if (top[j])
            begin
                r = r ^ GEN[j];
            end
        end
        return r;
    endfunction

    // character to symbol, msb set when not in the charset
    function automatic logic [5:0] char_to_sym(input logic [7:0] c);
        logic [7:0] lc;
        logic [5:0] r;
        lc = (c inside {[8'h41:8'h5A]}) ? (c + 8'd32) : c;
        r  = 6'b100000;
        for (int i = 0; i < 32; i++)
        begin
            if (CHARSET[i] == lc)
            begin
                r = {1'b0, 5'(i)};
            end
        end
        return r;
    endfunction

endpackage

FILE: src/bsc_front.sv
// front end: takes input words and classifies them for the back end
`timescale 1ns / 1ps

module bsc_front
    import bsc_pkg::*;
(
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // value
    input  logic [1:0] s_axis_tuser,   // cmd
    input  logic       q_full,
    output logic       q_push,
    output op_t        q_op
);

    logic [5:0] dec;

    // accept whenever the queue has room, reserved command is dropped
    assign s_axis_tready = !q_full;

    always_comb
    begin
        q_push = s_axis_tvalid && !q_full;
        case (s_axis_tuser)
            CMD_HRP, CMD_DATA, CMD_END: ;
            default: q_push = 1'b0;
        endcase
    end

    // classify the character both ways, back end picks by mode
    assign dec = char_to_sym(s_axis_tdata);

    always_comb
    begin
        q_op.kind      = s_axis_tuser;
        q_op.is_upper  = s_axis_tdata inside {[8'h41:8'h5A]};
        q_op.is_lower  = s_axis_tdata inside {[8'h61:8'h7A]};
        q_op.lc        = q_op.is_upper ? (s_axis_tdata + 8'd32) : s_axis_tdata;
        q_op.range_bad = !(s_axis_tdata inside {[8'd33:8'd126]});
        q_op.enc_bad   = |s_axis_tdata[7:5];
        q_op.enc_sym   = s_axis_tdata[4:0];
        q_op.enc_char  = CHARSET[s_axis_tdata[4:0]];
        q_op.dec_bad   = dec[5];
        q_op.dec_sym   = dec[5] ? 5'd0 : dec[4:0];
    end

endmodule

FILE: src/bsc_queue.sv
// small fifo of classified words between front and back
`timescale 1ns / 1ps

module bsc_queue
    import bsc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    output logic full,
    input  logic pop,
    output logic empty,
    output op_t  head
);

    localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW = $clog2(QDEPTH + 1);

    op_t              ent_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QCW-1:0]   count_reg;

    assign full  = (count_reg == QCW'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = ent_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

FILE: src/bsc_back.sv
// back end: checksum, hrp buffer replay, symbol delay and result register
`timescale 1ns / 1ps

module bsc_back
    import bsc_pkg::*;
#(
    parameter int HRP_MAX = HRP_MAX_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       mode,
    input  logic       head_valid,
    input  op_t        head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_value,
    output logic [2:0] out_status,
    output logic       out_last
);

    localparam int AW = (HRP_MAX > 1) ? $clog2(HRP_MAX) : 1;
    localparam int CW = $clog2(HRP_MAX + 1);
    localparam logic [CW-1:0] HMAX = CW'(HRP_MAX);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_BND    = 6'b000010,
        S_REPLAY = 6'b000100,
        S_SEP    = 6'b001000,
        S_PAD    = 6'b010000,
        S_EMIT   = 6'b100000
    } state_t;

    state_t        state_reg, state_next;
    logic [29:0]   acc_reg, acc_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] idx_inc;
    logic          in_data_reg, in_data_next;
    logic          up_reg, up_next;
    logic          low_reg, low_next;
    logic [2:0]    err_reg, err_next;
    logic [4:0]    dly_reg [6];
    logic [4:0]    dly_next [6];
    logic [2:0]    dcnt_reg, dcnt_next;
    logic [2:0]    step_reg, step_next;
    logic [2:0]    st_reg, st_next;
    logic [2:0]    st_calc;
    logic [29:0]   pad_acc;

    logic [4:0]    hrp_mem [HRP_MAX];
    logic [4:0]    rdata_reg;
    logic          mem_we;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    logic          out_valid_reg;
    logic [7:0]    out_value_reg;
    logic [2:0]    out_status_reg;
    logic          out_last_reg;
    logic          emit_ok;
    logic          emit;
    logic [7:0]    emit_value;
    logic [2:0]    emit_status;
    logic          emit_last;
    logic          do_clear;

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;
    assign emit_ok    = !out_valid_reg || out_ready;
    assign idx_inc    = idx_reg + 1'b1;
    assign pad_acc    = pm_step(acc_reg, 5'd0);

    // end-of-string status by priority
    always_comb
    begin
        if (up_reg && low_reg)
        begin
            st_calc = ST_MIXED;
        end
        else if (cnt_reg == '0 || (!mode && dcnt_reg < 3'd6))
        begin
            st_calc = ST_SHORT;
        end
        else if (err_reg != ST_OK)
        begin
            st_calc = err_reg;
        end
        else if (!mode && acc_reg != 30'd1)
        begin
            st_calc = ST_CHKSUM;
        end
        else
        begin
            st_calc = ST_OK;
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        in_data_next = in_data_reg;
        up_next      = up_reg;
        low_next     = low_reg;
        err_next     = err_reg;
        dly_next     = dly_reg;
        dcnt_next    = dcnt_reg;
        step_next    = step_reg;
        st_next      = st_reg;
        pop          = 1'b0;
        mem_we       = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = '0;
        emit         = 1'b0;
        emit_value   = '0;
        emit_status  = ST_OK;
        emit_last    = 1'b0;
        do_clear     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    case (head.kind)
                        CMD_HRP:
                        begin
                            if (in_data_reg)
                            begin
                                // hrp character after data: dropped
                                pop = 1'b1;
                                if (err_reg == ST_OK)
                                begin
                                    err_next = ST_BADCHAR;
                                end
                            end
                            else if (emit_ok)
                            begin
                                pop        = 1'b1;
                                emit       = 1'b1;
                                emit_value = head.lc;
                                up_next    = up_reg | head.is_upper;
                                low_next   = low_reg | head.is_lower;
                                if (err_reg == ST_OK)
                                begin
                                    if (head.range_bad)
                                    begin
                                        err_next = ST_BADCHAR;
                                    end
                                    else if (cnt_reg >= HMAX)
                                    begin
                                        err_next = ST_HRPLONG;
                                    end
                                end
                                if (cnt_reg < HMAX)
                                begin
                                    acc_next = pm_step(acc_reg, {2'b00, head.lc[7:5]});
                                    mem_we   = 1'b1;
                                    cnt_next = cnt_reg + 1'b1;
                                end
                            end
                        end
                        CMD_DATA, CMD_END:
                        begin
                            if (!in_data_reg)
                            begin
                                state_next = S_BND;
                            end
                            else if (head.kind == CMD_DATA)
                            begin
                                if (emit_ok)
                                begin
                                    pop = 1'b1;
                                    if (mode)
                                    begin
                                        // encode a symbol
                                        emit       = 1'b1;
                                        emit_value = head.enc_char;
                                        acc_next   = pm_step(acc_reg, head.enc_sym);
                                        if (err_reg == ST_OK && head.enc_bad)
                                        begin
                                            err_next = ST_BADSYM;
                                        end
                                    end
                                    else
                                    begin
                                        // decode a character, payload delayed six
                                        up_next  = up_reg | head.is_upper;
                                        low_next = low_reg | head.is_lower;
                                        acc_next = pm_step(acc_reg, head.dec_sym);
                                        if (err_reg == ST_OK && head.dec_bad)
                                        begin
                                            err_next = ST_BADCHAR;
                                        end
                                        if (dcnt_reg == 3'd6)
                                        begin
                                            emit       = 1'b1;
                                            emit_value = {3'b000, dly_reg[0]};
                                        end
                                        else
                                        begin
                                            dcnt_next = dcnt_reg + 1'b1;
                                        end
                                        for (int i = 0; i < 5; i++)
                                        begin
                                            dly_next[i] = dly_reg[i+1];
                                        end
                                        dly_next[5] = head.dec_sym;
                                    end
                                end
                            end
                            else if (mode)
                            begin
                                // encode end: pad the checksum
                                pop        = 1'b1;
                                st_next    = st_calc;
                                step_next  = '0;
                                state_next = S_PAD;
                            end
                            else if (emit_ok)
                            begin
                                pop         = 1'b1;
                                emit        = 1'b1;
                                emit_status = st_calc;
                                emit_last   = 1'b1;
                                do_clear    = 1'b1;
                            end
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            S_BND:
            begin
                acc_next   = pad_acc;
                rd_en      = 1'b1;
                idx_next   = '0;
                state_next = S_REPLAY;
            end
            S_REPLAY:
            begin
                // fold buffered hrp low bits, one per cycle
                if (idx_reg < cnt_reg)
                begin
                    acc_next = pm_step(acc_reg, rdata_reg);
                    idx_next = idx_inc;
                    if (idx_inc < HMAX)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = idx_inc[AW-1:0];
                    end
                end
                else
                begin
                    in_data_next = 1'b1;
                    state_next   = mode ? S_SEP : S_IDLE;
                end
            end
            S_SEP:
            begin
                if (emit_ok)
                begin
                    emit       = 1'b1;
                    emit_value = SEP_CHAR;
                    state_next = S_IDLE;
                end
            end
            S_PAD:
            begin
                if (step_reg == 3'd5)
                begin
                    acc_next   = pad_acc ^ 30'd1;
                    step_next  = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    acc_next  = pad_acc;
                    step_next = step_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                // checksum characters, most significant group first
                if (emit_ok)
                begin
                    emit       = 1'b1;
                    emit_value = CHARSET[acc_reg[29:25]];
                    acc_next   = {acc_reg[24:0], 5'd0};
                    if (step_reg == 3'd5)
                    begin
                        emit_status = st_reg;
                        emit_last   = 1'b1;
                        do_clear    = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // string finished: back to the empty string
        if (do_clear)
        begin
            acc_next     = 30'd1;
            cnt_next     = '0;
            in_data_next = 1'b0;
            up_next      = 1'b0;
            low_next     = 1'b0;
            err_next     = ST_OK;
            dcnt_next    = '0;
            step_next    = '0;
            for (int i = 0; i < 6; i++)
            begin
                dly_next[i] = '0;
            end
        end
    end

    // control and string state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_reg       <= 30'd1;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            in_data_reg   <= 1'b0;
            up_reg        <= 1'b0;
            low_reg       <= 1'b0;
            err_reg       <= ST_OK;
            dcnt_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                dly_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            in_data_reg <= in_data_next;
            up_reg      <= up_next;
            low_reg     <= low_next;
            err_reg     <= err_next;
            dcnt_reg    <= dcnt_next;
            step_reg    <= step_next;
            dly_reg     <= dly_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload and end status
    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
        if (emit)
        begin
            out_value_reg  <= emit_value;
            out_status_reg <= emit_status;
            out_last_reg   <= emit_last;
        end
    end

    // hrp low-bit buffer
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hrp_mem[cnt_reg[AW-1:0]] <= head.lc[4:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= hrp_mem[rd_addr];
        end
    end

endmodule

FILE: src/bech32_string_codec_top.sv
// top level of the bech32 string codec
`timescale 1ns / 1ps

// Bech32 string codec. One string goes in as hrp characters (tuser 0), then
// data words (tuser 1), then an end word (tuser 2); tuser 3 words are
// dropped. Register 0 (mode) at address 0 picks decode (0) or encode (1).
// Input words land in a two-entry queue; the back end runs them through the
// polymod checksum and writes results into an output register, so input
// keeps flowing while the receiver stalls, until the queue fills. Hrp
// characters and data words are each handled in the idle state of the back
// end; words that give output wait while the output register cannot take
// one. The first data or end word of a string first passes the boundary and
// replay states, which replay the buffered hrp low bits from the buffer
// memory, and in encode the separator state. An encode end takes 6 padding
// steps of the checksum unit and then gives one word per checksum
// character; a decode end gives a single status word. The final word of a
// string has tlast set and carries the status. A stalled receiver holds the
// output register, which holds back the back end and then the queue.
// Reset empties the queue and output register, clears the string state and
// sets mode to decode.

module bech32_string_codec_top
    import bsc_pkg::*;
#(
    parameter int HRP_MAX = HRP_MAX_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] value_res, [10:8] status, rest zero
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       mode_reg;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    op_t        q_op;
    op_t        q_head;
    logic [7:0] res_value;
    logic [2:0] res_status;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
        begin
            mode_reg <= pwdata[0];
        end
    end

    // front end
    bsc_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_op          (q_op)
    );

    // queue
    bsc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (q_op),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .head    (q_head)
    );

    // back end
    bsc_back #(
        .HRP_MAX (HRP_MAX)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (mode_reg),
        .head_valid (!q_empty),
        .head       (q_head),
        .pop        (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_value  (res_value),
        .out_status (res_status),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, res_status, res_value};

    // checks
    a_push_room : assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue written while full");

    a_pop_data : assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue read while empty");

    a_status_last : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[10:8] == ST_OK))
        else $error("status on a word that is not last");

endmodule

FILE: bench/bech32_string_codec_top_tb.sv
// testbench for the bech32 string codec top level: strings checked word by word
`timescale 1ns / 1ps

module bech32_string_codec_top_tb;
    import bsc_pkg::*;

    localparam int          HRP_LIMIT    = HRP_MAX_DEF;
    localparam logic [1:0]  CMD_NONE     = 2'd3;
    localparam logic [2:0]  MODE_ADDR    = 3'd0;
    localparam logic        MODE_DECODE  = 1'b0;
    localparam logic        MODE_ENCODE  = 1'b1;
    localparam int          SETTLE       = 80;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          RANDOM_WORDS = 140;
    localparam int          MAX_SHOWN    = 10;

    // symbol alphabet, symbol 0 in the top byte
    localparam logic [8*32-1:0] ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

    // bch generator terms of the checksum
    localparam logic [29:0] BCH_GEN [5] = '{
        30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
    };

    typedef logic [7:0] char_q_t [$];

    typedef struct packed {
        logic [7:0] ch;
        logic [2:0] st;
        logic       lst;
    } word_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;
    logic [1:0]  s_axis_tuser  = 2'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = 3'd0;
    logic [31:0] pwdata        = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // shared run control
    logic        send_gaps   = 1'b1;
    logic        recv_gaps   = 1'b1;
    logic        hold_req    = 1'b0;
    int          hold_left   = 0;
    int          words_sent  = 0;
    int          err_count   = 0;
    int          cycle_count = 0;

    // predictor state
    logic        enc_mode;
    logic [29:0] poly_acc;
    logic [4:0]  hrp_low [HRP_LIMIT];
    int          hrp_len;
    logic        past_sep;
    logic        upper_seen;
    logic        lower_seen;
    logic [2:0]  first_err;
    logic [4:0]  sym_pipe [6];
    int          sym_seen;
    word_t       due_words [$];

    bech32_string_codec_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // one checksum step
    function automatic logic [29:0] bch_fold(input logic [29:0] acc, input logic [4:0] sym);
        logic [29:0] r;
        r = {acc[24:0], sym};
        for (int j = 0; j < 5; j++)
        begin
            if (acc[25 + j])
                r = r ^ BCH_GEN[j];
        end
        return r;
    endfunction

    // six zero steps and the final flip give the checksum
    function automatic logic [29:0] checksum_of(input logic [29:0] acc);
        logic [29:0] r;
        r = acc;
        for (int i = 0; i < 6; i++)
            r = bch_fold(r, 5'd0);
        return r ^ 30'd1;
    endfunction

    function automatic logic [7:0] sym_char(input logic [4:0] s);
        return ALPHABET[8 * (31 - s) +: 8];
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    // character to symbol, bit 5 set when outside the alphabet
    function automatic logic [5:0] char_sym(input logic [7:0] c);
        logic [7:0] lc;
        lc = to_lower(c);
        for (int i = 0; i < 32; i++)
        begin
            if (sym_char(5'(i)) == lc)
                return 6'(i);
        end
        return 6'd32;
    endfunction

    function automatic char_q_t chars(input string s);
        char_q_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    // payload characters followed by a correct checksum for this hrp
    function automatic char_q_t checked_data(input char_q_t hrp, input char_q_t syms);
        char_q_t     q;
        logic [29:0] acc;
        logic [7:0]  lc;
        acc = 30'd1;
        foreach (hrp[i])
        begin
            lc  = to_lower(hrp[i]);
            acc = bch_fold(acc, {2'b00, lc[7:5]});
        end
        acc = bch_fold(acc, 5'd0);
        foreach (hrp[i])
        begin
            lc  = to_lower(hrp[i]);
            acc = bch_fold(acc, lc[4:0]);
        end
        foreach (syms[i])
        begin
            acc = bch_fold(acc, syms[i][4:0]);
            q.push_back(sym_char(syms[i][4:0]));
        end
        acc = checksum_of(acc);
        for (int i = 0; i < 6; i++)
            q.push_back(sym_char(acc[25 - 5 * i +: 5]));
        return q;
    endfunction

    // string state back to its idle values
    function automatic void clear_string();
        poly_acc   = 30'd1;
        hrp_len    = 0;
        past_sep   = 1'b0;
        upper_seen = 1'b0;
        lower_seen = 1'b0;
        first_err  = ST_OK;
        sym_seen   = 0;
        for (int i = 0; i < HRP_LIMIT; i++)
            hrp_low[i] = 5'd0;
        for (int i = 0; i < 6; i++)
            sym_pipe[i] = 5'd0;
    endfunction

    function automatic void latch_err(input logic [2:0] e);
        if (first_err == ST_OK)
            first_err = e;
    endfunction

    function automatic void note_case(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
            upper_seen = 1'b1;
        if (c >= "a" && c <= "z")
            lower_seen = 1'b1;
    endfunction

    function automatic void expect_word(input logic [7:0] ch, input logic [2:0] st,
                                        input logic lst);
        word_t w;
        w.ch  = ch;
        w.st  = st;
        w.lst = lst;
        due_words.push_back(w);
    endfunction

    // fold in the buffered hrp low bits at the separator
    function automatic void enter_data();
        if (!past_sep)
        begin
            poly_acc = bch_fold(poly_acc, 5'd0);
            for (int i = 0; i < hrp_len; i++)
                poly_acc = bch_fold(poly_acc, hrp_low[i]);
            past_sep = 1'b1;
            if (enc_mode)
                expect_word(SEP_CHAR, ST_OK, 1'b0);
        end
    endfunction

    // one accepted input word through the codec
    function automatic void codec_step(input logic [1:0] cmd, input logic [7:0] v);
        logic [7:0]  lc;
        logic [5:0]  s;
        logic [29:0] p;
        logic [2:0]  st;
        lc = to_lower(v);
        case (cmd)
            CMD_HRP:
            begin
                if (past_sep)
                begin
                    // hrp after data is dropped
                    latch_err(ST_BADCHAR);
                end
                else
                begin
                    if (v < 8'd33 || v > 8'd126)
                        latch_err(ST_BADCHAR);
                    note_case(v);
                    if (hrp_len >= HRP_LIMIT)
                        latch_err(ST_HRPLONG);
                    else
                    begin
                        poly_acc = bch_fold(poly_acc, {2'b00, lc[7:5]});
                        hrp_low[hrp_len] = lc[4:0];
                        hrp_len++;
                    end
                    expect_word(lc, ST_OK, 1'b0);
                end
            end
            CMD_DATA:
            begin
                enter_data();
                if (enc_mode)
                begin
                    if (v[7:5] != 3'd0)
                        latch_err(ST_BADSYM);
                    poly_acc = bch_fold(poly_acc, v[4:0]);
                    expect_word(sym_char(v[4:0]), ST_OK, 1'b0);
                end
                else
                begin
                    s = char_sym(v);
                    note_case(v);
                    if (s[5])
                    begin
                        latch_err(ST_BADCHAR);
                        s = 6'd0;
                    end
                    poly_acc = bch_fold(poly_acc, s[4:0]);
                    // payload trails the input by six symbols
                    if (sym_seen >= 6)
                        expect_word({3'd0, sym_pipe[0]}, ST_OK, 1'b0);
                    else
                        sym_seen++;
                    for (int i = 0; i < 5; i++)
                        sym_pipe[i] = sym_pipe[i + 1];
                    sym_pipe[5] = s[4:0];
                end
            end
            CMD_END:
            begin
                enter_data();
                if (upper_seen && lower_seen)
                    st = ST_MIXED;
                else if (hrp_len == 0 || (!enc_mode && sym_seen < 6))
                    st = ST_SHORT;
                else if (first_err != ST_OK)
                    st = first_err;
                else if (!enc_mode && poly_acc != 30'd1)
                    st = ST_CHKSUM;
                else
                    st = ST_OK;
                if (enc_mode)
                begin
                    p = checksum_of(poly_acc);
                    for (int i = 0; i < 6; i++)
                        expect_word(sym_char(p[25 - 5 * i +: 5]), (i == 5) ? st : ST_OK,
                                    i == 5);
                end
                else
                    expect_word(8'd0, st, 1'b1);
                clear_string();
            end
            default:
            begin
            end
        endcase
    endfunction

    // compare one output word with the oldest expectation
    function automatic void check_word();
        word_t want;
        if (due_words.size() == 0)
        begin
            err_count++;
            if (err_count <= MAX_SHOWN)
                $display("unexpected word: value %02h status %0d last %0b",
                         m_axis_tdata[7:0], m_axis_tdata[10:8], m_axis_tlast);
        end
        else
        begin
            want = due_words.pop_front();
            if (m_axis_tdata[7:0] != want.ch || m_axis_tdata[10:8] != want.st ||
                m_axis_tlast != want.lst)
            begin
                err_count++;
                if (err_count <= MAX_SHOWN)
                    $display("mismatch: value %02h status %0d last %0b, wanted %02h %0d %0b",
                             m_axis_tdata[7:0], m_axis_tdata[10:8], m_axis_tlast,
                             want.ch, want.st, want.lst);
            end
        end
    endfunction

    // watch both streams
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                codec_step(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                check_word();
        end
    end

    // receiver: random stalls plus a long hold when a test asks for one
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= !(recv_gaps && $urandom_range(99) < 16);
    end

    // run time limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("bech32_string_codec_top_tb: errors");
            $finish;
        end
    end

    // offer one word and wait for its handshake
    task automatic send_word(input logic [1:0] cmd, input logic [7:0] v);
        while (send_gaps && $urandom_range(99) < 16)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= v;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (cmd != CMD_NONE)
            words_sent++;
    endtask

    task automatic send_string(input char_q_t hrp, input char_q_t data);
        foreach (hrp[i])
            send_word(CMD_HRP, hrp[i]);
        foreach (data[i])
            send_word(CMD_DATA, data[i]);
        send_word(CMD_END, 8'($urandom));
    endtask

    // stop sending until every expected word is back and the block settles
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (due_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // write the mode register, then read it back
    task automatic set_mode(input logic m);
        wait_idle();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= MODE_ADDR;
        pwdata  <= {31'd0, m};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        enc_mode = m;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {31'd0, m})
        begin
            err_count++;
            if (err_count <= MAX_SHOWN)
                $display("mode readback %08h, wanted %08h", prdata, {31'd0, m});
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // short published strings in both directions
    task automatic test_known_vectors();
        char_q_t none;
        set_mode(MODE_DECODE);
        send_string(chars("A"), chars("2UEL5L"));
        set_mode(MODE_ENCODE);
        send_string(chars("a"), none);
    endtask

    // extreme field values in both modes
    task automatic test_field_extremes();
        char_q_t hrp;
        char_q_t data;
        set_mode(MODE_DECODE);
        hrp.push_back(8'h00);
        hrp.push_back(8'hff);
        hrp.push_back("!");
        hrp.push_back("~");
        data = chars("qqqqqq");
        data.push_back(8'hff);
        data.push_back(8'h80);
        send_string(hrp, data);
        set_mode(MODE_ENCODE);
        data.delete();
        data.push_back(8'd0);
        data.push_back(8'd31);
        data.push_back(8'd32);
        data.push_back(8'hff);
        send_string(chars("z"), data);
    endtask

    // letter case rules differ by mode
    task automatic test_case_rules();
        char_q_t data;
        data.push_back(8'd1);
        data.push_back(8'd2);
        send_string(chars("aB"), data);
        send_string(chars("AB"), data);
        set_mode(MODE_DECODE);
        send_string(chars("a"), chars("QQQQQQ"));
    endtask

    // empty hrp and too few data characters
    task automatic test_short_parts();
        char_q_t none;
        char_q_t data;
        send_string(none, none);
        send_string(chars("ab"), chars("qqq"));
        set_mode(MODE_ENCODE);
        data.push_back(8'd5);
        send_string(none, data);
    endtask

    // hrp after data and ignored commands
    task automatic test_misordered();
        set_mode(MODE_DECODE);
        send_word(CMD_HRP, "a");
        send_word(CMD_NONE, "b");
        repeat (4) send_word(CMD_DATA, "q");
        send_word(CMD_HRP, "z");
        send_word(CMD_NONE, 8'hff);
        repeat (4) send_word(CMD_DATA, "p");
        send_word(CMD_END, 8'h00);
    endtask

    // hrp beyond the buffer depth
    task automatic test_hrp_too_long();
        char_q_t hrp;
        char_q_t data;
        set_mode(MODE_ENCODE);
        for (int i = 0; i < HRP_LIMIT + 2; i++)
            hrp.push_back(8'("a" + i % 26));
        data.push_back(8'd9);
        data.push_back(8'd17);
        send_string(hrp, data);
    endtask

    // a valid string, then the same with one character changed
    task automatic test_checksum_error();
        char_q_t hrp;
        char_q_t syms;
        char_q_t data;
        set_mode(MODE_DECODE);
        hrp = chars("hx");
        syms.push_back(8'd3);
        syms.push_back(8'd17);
        syms.push_back(8'd30);
        data = checked_data(hrp, syms);
        send_string(hrp, data);
        data[2] = (data[2] == "q") ? 8'("p") : 8'("q");
        send_string(hrp, data);
    endtask

    // mode flipped between hrp and data of one string
    task automatic test_mode_midstring();
        set_mode(MODE_DECODE);
        send_word(CMD_HRP, "m");
        send_word(CMD_HRP, "x");
        set_mode(MODE_ENCODE);
        send_word(CMD_DATA, 8'd7);
        send_word(CMD_DATA, 8'd22);
        send_word(CMD_DATA, 8'd0);
        send_word(CMD_END, 8'h5a);
    endtask

    // long receiver hold while the sender keeps offering
    task automatic test_backpressure();
        char_q_t data;
        set_mode(MODE_ENCODE);
        for (int i = 0; i < 24; i++)
            data.push_back(8'(i));
        hold_req = 1'b1;
        send_string(chars("hold"), data);
    endtask

    // one random string: mostly well formed, some corrupted, some noise
    task automatic random_string();
        char_q_t    hrp;
        char_q_t    syms;
        char_q_t    data;
        logic [7:0] c;
        int         n;
        int         pos;
        logic       upper;
        if ($urandom_range(99) < 12)
        begin
            n = $urandom_range(12, 1);
            repeat (n) send_word(2'($urandom), 8'($urandom));
            send_word(CMD_END, 8'($urandom));
        end
        else
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(HRP_LIMIT + 2, 8)
                                          : $urandom_range(6, 1);
            repeat (n)
            begin
                c = $urandom_range(1) ? 8'("a" + $urandom_range(25))
                                      : 8'($urandom_range(126, 33));
                hrp.push_back(to_lower(c));
            end
            upper = ($urandom_range(3) == 0);
            if (upper)
            begin
                foreach (hrp[i])
                    hrp[i] = to_upper(hrp[i]);
            end
            if (enc_mode)
            begin
                n = $urandom_range(14);
                repeat (n) data.push_back(($urandom_range(19) == 0) ? 8'($urandom)
                                                                    : 8'($urandom_range(31)));
            end
            else
            begin
                n = $urandom_range(10);
                repeat (n) syms.push_back(8'($urandom_range(31)));
                data = checked_data(hrp, syms);
                if (upper)
                begin
                    foreach (data[i])
                        data[i] = to_upper(data[i]);
                end
                // damage one character now and then
                if ($urandom_range(9) < 3)
                begin
                    pos = $urandom_range(data.size() - 1);
                    case ($urandom_range(3))
                        0: data[pos] = sym_char(5'($urandom));
                        1: data[pos] = 8'($urandom);
                        2: data.delete(pos);
                        default:
                        begin
                            c = to_lower(data[pos]);
                            if (c >= "a" && c <= "z")
                                data[pos] = data[pos] ^ 8'h20;
                        end
                    endcase
                end
            end
            send_string(hrp, data);
        end
    endtask

    // random phases alternating the mode, one without any idling
    task automatic test_random_strings();
        int goal;
        for (int ph = 0; ph < 5; ph++)
        begin
            set_mode((ph % 2) == 1 ? MODE_ENCODE : MODE_DECODE);
            send_gaps = (ph != 2);
            recv_gaps = (ph != 2);
            goal = words_sent + RANDOM_WORDS / 5;
            while (words_sent < goal)
                random_string();
        end
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
    endtask

    // test sequence
    initial
    begin
        enc_mode = MODE_DECODE;
        clear_string();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_known_vectors();
        test_field_extremes();
        test_case_rules();
        test_short_parts();
        test_misordered();
        test_hrp_too_long();
        test_checksum_error();
        test_mode_midstring();
        test_backpressure();
        test_random_strings();
        wait_idle();
        if (err_count == 0 && due_words.size() == 0)
            $display("bech32_string_codec_top_tb: clean");
        else
            $display("bech32_string_codec_top_tb: errors");
        $finish;
    end

endmodule
